// ===== design/obm_pkg.sv =====
// Package with the sizes, command codes and shared types of the overflow bucket marker.
`default_nettype none

package obm_pkg;

  // Block dimensions.
  localparam int NUM_BUCKETS = 1024;
  localparam int STRIPES     = 16;
  localparam int COUNT_WIDTH = 32;

  // Derived widths. Tags are stored one row per group of STRIPES buckets,
  // so a row holds one bit for each stripe.
  localparam int ROWS     = NUM_BUCKETS / STRIPES;
  localparam int STRIPE_W = $clog2(STRIPES);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int CUR_W    = $clog2(STRIPES + 1);
  localparam int SCNT_W   = $clog2(ROWS + 1);
  localparam int TOTAL_W  = $clog2(NUM_BUCKETS + 1);
  localparam int CMD_W    = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_FENCE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_AVAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT       = 3'd4;

  // Operation for the tally unit, issued by the sequencer.
  typedef struct packed {
    logic                clear;      // zero all counts
    logic                inc;        // one more tagged bucket
    logic                dec;        // one fewer tagged bucket
    logic                ahead;      // change also applies to the remaining count
    logic                load_left;  // load remaining count from the stripe count
    logic                left_zero;  // load zero instead (listing exhausted)
    logic [STRIPE_W-1:0] addr;       // stripe addressed
  } tally_op_t;

endpackage

`default_nettype wire

// ===== design/obm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module obm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/obm_tally.sv =====
// Tally unit: per-stripe tag counts, running total and remaining count of the current stripe.
`default_nettype none

module obm_tally (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire obm_pkg::tally_op_t       op,
  output logic [obm_pkg::TOTAL_W-1:0]   total,
  output logic [obm_pkg::SCNT_W-1:0]    left
);
  import obm_pkg::*;

  logic [SCNT_W-1:0]  cnt_r [STRIPES];
  logic [TOTAL_W-1:0] total_r;
  logic [SCNT_W-1:0]  left_r;
  logic [SCNT_W-1:0]  cnt_sel;

  assign cnt_sel = cnt_r[op.addr];
  assign total   = total_r;
  assign left    = left_r;

  // Counts move by one on every tag change; the remaining count is reloaded on stripe entry.
  always_ff @(posedge clk) begin
    if (!rst_n || op.clear) begin
      for (int i = 0; i < STRIPES; i++) begin
        cnt_r[i] <= '0;
      end
      total_r <= '0;
      left_r  <= '0;
    end else begin
      if (op.inc) begin
        cnt_r[op.addr] <= cnt_sel + SCNT_W'(1);
        total_r        <= total_r + TOTAL_W'(1);
        if (op.ahead) begin
          left_r <= left_r + SCNT_W'(1);
        end
      end else if (op.dec) begin
        cnt_r[op.addr] <= cnt_sel - SCNT_W'(1);
        total_r        <= total_r - TOTAL_W'(1);
        if (op.ahead) begin
          left_r <= left_r - SCNT_W'(1);
        end
      end
      if (op.load_left) begin
        left_r <= op.left_zero ? '0 : cnt_sel;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/overflow_bucket_marker.sv =====
// Top level of the overflow bucket marker: command sequencer, tag store and result register.
// Usage:
// A request on the in_ channel carries a command: clear, mark by fill/fence, mark by available,
// start list or next. Every request gives exactly one result on the out_ channel: found,
// bucket_id and the number of tagged buckets after the command.
// in_stall is high while a request is being worked on; one request is handled at a time.
// A clear or an unknown code goes straight to the response; a mark reads the bucket's row and
// then writes it back. A start or next walks the tag store one row at a time in the current
// stripe (64 rows per stripe), reading each row and then checking it, and steps over each
// stripe without tags by loading the next stripe's remaining count. Only the stripe holding
// the hit is scanned.
// The listing time is set by the single read port of the tag RAM, which the scan shares
// with the marking path.
// The result sits in an output register, so a new request is taken while an earlier result
// is still stalled; the sequencer holds the next result until the register is free.
// Reset (synchronous, rst_n low) and the clear command both empty all tags at once through
// per-row valid bits, so no clearing pass is needed.
`default_nettype none

module overflow_bucket_marker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [obm_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [obm_pkg::BUCKET_W-1:0]      in_bucket,
  input  wire logic [obm_pkg::COUNT_WIDTH-1:0]   in_fill_count,
  input  wire logic [obm_pkg::COUNT_WIDTH-1:0]   in_fence_value,
  input  wire logic signed [31:0]                in_available,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_found,
  output logic [obm_pkg::BUCKET_W-1:0]           out_bucket_id,
  output logic [obm_pkg::TOTAL_W-1:0]            out_marked_total
);
  import obm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MARK_RD  = 8'b0000_0010,
    S_MARK_WR  = 8'b0000_0100,
    S_LIST     = 8'b0000_1000,
    S_LOAD     = 8'b0001_0000,
    S_SCAN_RD  = 8'b0010_0000,
    S_SCAN_CHK = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CUR_W-1:0]      cur_r, cur_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [ROWS-1:0]       rowval_r, rowval_nxt;
  logic [BUCKET_W-1:0]   bucket_r, bucket_nxt;
  logic                  tag_r, tag_nxt;
  logic                  found_r, found_nxt;
  logic [BUCKET_W-1:0]   id_r, id_nxt;
  logic                  ret_list_r, ret_list_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [BUCKET_W-1:0]   out_id_r, out_id_nxt;
  logic [TOTAL_W-1:0]    out_total_r, out_total_nxt;

  logic                  accept;
  logic [COUNT_WIDTH-1:0] diff;
  logic                  tag_in;
  logic [ROW_W-1:0]      bkt_row;
  logic [STRIPE_W-1:0]   bkt_col;
  logic [STRIPE_W-1:0]   cur_col;
  logic [STRIPES-1:0]    mark_base;
  logic [STRIPES-1:0]    scan_base;
  logic                  ahead;

  logic                  ram_we;
  logic [ROW_W-1:0]      ram_waddr;
  logic [STRIPES-1:0]    ram_wdata;
  logic [ROW_W-1:0]      ram_raddr;
  logic [STRIPES-1:0]    ram_rdata;

  tally_op_t             tally_op;
  logic [TOTAL_W-1:0]    total;
  logic [SCNT_W-1:0]     left;

  // Tag store: one row per group of STRIPES buckets, one bit per stripe.
  obm_ram #(
    .WIDTH (STRIPES),
    .DEPTH (ROWS)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  obm_tally u_tally (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (tally_op),
    .total (total),
    .left  (left)
  );

  // Handshake and request decode.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign diff     = in_fence_value - in_fill_count;
  assign tag_in   = (in_cmd == CMD_MARK_FENCE) ? diff[COUNT_WIDTH-1] : in_available[31];

  assign bkt_row  = bucket_r[BUCKET_W-1:STRIPE_W];
  assign bkt_col  = bucket_r[STRIPE_W-1:0];
  assign cur_col  = cur_r[STRIPE_W-1:0];

  // A row never written since reset or clear reads as all zero.
  assign mark_base = rowval_r[bkt_row] ? ram_rdata : '0;
  assign scan_base = rowval_r[row_r] ? ram_rdata : '0;

  // A mark in the current stripe at or past the cursor changes the remaining count.
  assign ahead = ({1'b0, bkt_col} == cur_r) && (bkt_row >= row_r);

  assign ram_raddr = (state_r == S_MARK_RD) ? bkt_row : row_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    row_nxt       = row_r;
    rowval_nxt    = rowval_r;
    bucket_nxt    = bucket_r;
    tag_nxt       = tag_r;
    found_nxt     = found_r;
    id_nxt        = id_r;
    ret_list_nxt  = ret_list_r;
    tally_op      = '0;
    ram_we        = 1'b0;
    ram_waddr     = row_r;
    ram_wdata     = scan_base;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_id_nxt    = out_id_r;
    out_total_nxt = out_total_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          found_nxt  = 1'b0;
          id_nxt     = '0;
          bucket_nxt = in_bucket;
          tag_nxt    = tag_in;
          unique case (in_cmd) inside
            CMD_CLEAR: begin
              tally_op.clear = 1'b1;
              rowval_nxt     = '0;
              cur_nxt        = '0;
              row_nxt        = '0;
              state_nxt      = S_RESP;
            end
            CMD_MARK_FENCE, CMD_MARK_AVAIL: begin
              state_nxt = S_MARK_RD;
            end
            CMD_START: begin
              cur_nxt      = '0;
              row_nxt      = '0;
              ret_list_nxt = 1'b1;
              state_nxt    = S_LOAD;
            end
            CMD_NEXT: begin
              state_nxt = S_LIST;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_MARK_RD: begin
        state_nxt = S_MARK_WR;
      end

      // Replace the bucket's tag; counts follow only a real change.
      S_MARK_WR: begin
        ram_waddr          = bkt_row;
        ram_wdata          = mark_base;
        ram_wdata[bkt_col] = tag_r;
        if (mark_base[bkt_col] != tag_r) begin
          ram_we              = 1'b1;
          rowval_nxt[bkt_row] = 1'b1;
          tally_op.inc        = tag_r;
          tally_op.dec        = !tag_r;
          tally_op.ahead      = ahead;
          tally_op.addr       = bkt_col;
        end
        state_nxt = S_RESP;
      end

      // Head of the listing loop: scan this stripe or step to the next one.
      S_LIST: begin
        if (cur_r == CUR_W'(STRIPES)) begin
          state_nxt = S_RESP;
        end else if (left != '0) begin
          state_nxt = S_SCAN_RD;
        end else begin
          cur_nxt      = cur_r + CUR_W'(1);
          row_nxt      = '0;
          ret_list_nxt = 1'b1;
          state_nxt    = S_LOAD;
        end
      end

      // Stripe entry: load the remaining count of the new stripe.
      S_LOAD: begin
        tally_op.load_left = 1'b1;
        tally_op.left_zero = (cur_r == CUR_W'(STRIPES));
        tally_op.addr      = cur_col;
        state_nxt          = ret_list_r ? S_LIST : S_RESP;
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end

      // Check the stripe's bit in the row at the cursor; a hit is listed and untagged.
      S_SCAN_CHK: begin
        ram_waddr          = row_r;
        ram_wdata          = scan_base;
        ram_wdata[cur_col] = 1'b0;
        if (scan_base[cur_col]) begin
          ram_we         = 1'b1;
          tally_op.dec   = 1'b1;
          tally_op.ahead = 1'b1;
          tally_op.addr  = cur_col;
          found_nxt      = 1'b1;
          id_nxt         = {row_r, cur_col};
        end
        if (row_r == ROW_W'(ROWS - 1)) begin
          cur_nxt      = cur_r + CUR_W'(1);
          row_nxt      = '0;
          ret_list_nxt = !scan_base[cur_col];
          state_nxt    = S_LOAD;
        end else begin
          row_nxt   = row_r + ROW_W'(1);
          state_nxt = scan_base[cur_col] ? S_RESP : S_SCAN_RD;
        end
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_id_nxt    = id_r;
          out_total_nxt = total;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      row_r       <= '0;
      rowval_r    <= '0;
      ret_list_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      row_r       <= row_nxt;
      rowval_r    <= rowval_nxt;
      ret_list_r  <= ret_list_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    bucket_r    <= bucket_nxt;
    tag_r       <= tag_nxt;
    found_r     <= found_nxt;
    id_r        <= id_nxt;
    out_found_r <= out_found_nxt;
    out_id_r    <= out_id_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_bucket_id    = out_id_r;
  assign out_marked_total = out_total_r;

endmodule

`default_nettype wire

// ===== verif/obm_checker.sv =====
`timescale 1ns / 1ps
// Checker for the overflow bucket marker: watches both channels, predicts each result and compares.
module obm_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic [obm_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [obm_pkg::BUCKET_W-1:0]    in_bucket,
  input  wire logic [obm_pkg::COUNT_WIDTH-1:0] in_fill_count,
  input  wire logic [obm_pkg::COUNT_WIDTH-1:0] in_fence_value,
  input  wire logic [31:0]                     in_available,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic                            out_found,
  input  wire logic [obm_pkg::BUCKET_W-1:0]    out_bucket_id,
  input  wire logic [obm_pkg::TOTAL_W-1:0]     out_marked_total,
  output int                                   mismatch_count,
  output int                                   pending_count
);
  import obm_pkg::*;

  typedef struct packed {
    logic                found;
    logic [BUCKET_W-1:0] bucket_id;
    logic [TOTAL_W-1:0]  marked_total;
  } marker_result_t;

  // Predicted state of the block.
  bit             overflowed [NUM_BUCKETS];
  int             stripe_tally [STRIPES];
  int             walk_stripe;
  int             walk_left;
  int             walk_cursor;
  int             tag_total;
  marker_result_t expected_results [$];

  // Reset and the clear command both empty every tag and rewind the listing.
  function automatic void clear_marks();
    foreach (overflowed[b]) overflowed[b] = 1'b0;
    foreach (stripe_tally[s]) stripe_tally[s] = 0;
    walk_stripe = 0;
    walk_left = 0;
    walk_cursor = 0;
    tag_total = 0;
  endfunction

  // Move the listing to the first bucket of a stripe; STRIPES means exhausted.
  function automatic void enter_stripe(int s);
    walk_stripe = s;
    walk_cursor = s;
    walk_left = (s < STRIPES) ? stripe_tally[s] : 0;
  endfunction

  // Replace a bucket's tag and keep the counts in step with the change.
  function automatic void set_tag(int b, bit tag);
    int  s;
    bit  ahead;
    s = b % STRIPES;
    ahead = (s == walk_stripe) && (b >= walk_cursor);
    if (overflowed[b] == tag) return;
    overflowed[b] = tag;
    if (tag) begin
      stripe_tally[s]++;
      tag_total++;
      if (ahead) walk_left++;
    end else begin
      stripe_tally[s]--;
      tag_total--;
      if (ahead) walk_left--;
    end
  endfunction

  // Take the next tagged bucket of the listing and untag it.
  function automatic bit take_next_bucket(output int id);
    id = 0;
    while (walk_stripe < STRIPES) begin
      if (walk_left > 0) begin
        for (int n = walk_cursor; n < NUM_BUCKETS; n += STRIPES) begin
          if (overflowed[n]) begin
            overflowed[n] = 1'b0;
            stripe_tally[walk_stripe]--;
            tag_total--;
            walk_left--;
            id = n;
            walk_cursor = n + STRIPES;
            if (walk_cursor >= NUM_BUCKETS) enter_stripe(walk_stripe + 1);
            return 1'b1;
          end
        end
      end
      enter_stripe(walk_stripe + 1);
    end
    return 1'b0;
  endfunction

  // Apply one request to the predicted state and return the result it gives.
  function automatic marker_result_t predict_marker_result(
    logic [CMD_W-1:0]       cmd,
    logic [BUCKET_W-1:0]    bucket,
    logic [COUNT_WIDTH-1:0] fill,
    logic [COUNT_WIDTH-1:0] fence,
    logic [31:0]            avail
  );
    marker_result_t         r;
    logic [COUNT_WIDTH-1:0] headroom;
    int                     id;
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        clear_marks();
      end
      CMD_MARK_FENCE: begin
        headroom = fence - fill;
        set_tag(int'(bucket), headroom[COUNT_WIDTH-1]);
      end
      CMD_MARK_AVAIL: begin
        set_tag(int'(bucket), avail[31]);
      end
      CMD_START, CMD_NEXT: begin
        if (cmd == CMD_START) enter_stripe(0);
        if (take_next_bucket(id)) begin
          r.found = 1'b1;
          r.bucket_id = id[BUCKET_W-1:0];
        end
      end
      default: ;
    endcase
    r.marked_total = tag_total[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic report_field(string name, longint want, longint got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin : watch
    marker_result_t want;
    if (!rst_n) begin
      clear_marks();
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with none expected, found %0d bucket_id %0d total %0d",
                   $time, out_found, out_bucket_id, out_marked_total);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found)
            report_field("found", want.found, out_found);
          if (out_bucket_id !== want.bucket_id)
            report_field("bucket_id", want.bucket_id, out_bucket_id);
          if (out_marked_total !== want.marked_total)
            report_field("marked_total", want.marked_total, out_marked_total);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_marker_result(in_cmd, in_bucket, in_fill_count,
                                                         in_fence_value, in_available));
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== verif/tb_overflow_bucket_marker.sv =====
`timescale 1ns / 1ps
// Testbench top for the overflow bucket marker: stimulus, result backpressure and verdict.
module tb_overflow_bucket_marker;
  import obm_pkg::*;

  localparam int ITEM_TARGET  = 1300;
  localparam int IDLE_LIMIT   = 12000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RECENT_DEPTH = 8;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [CMD_W-1:0]       in_cmd;
  logic [BUCKET_W-1:0]    in_bucket;
  logic [COUNT_WIDTH-1:0] in_fill_count;
  logic [COUNT_WIDTH-1:0] in_fence_value;
  logic [31:0]            in_available;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_found;
  logic [BUCKET_W-1:0]    out_bucket_id;
  logic [TOTAL_W-1:0]     out_marked_total;

  int                     mismatch_count;
  int                     pending_count;
  int                     sent_count;
  int                     idle_cycles;
  bit                     calm;
  int                     focus_a;
  int                     focus_b;
  logic [BUCKET_W-1:0]    recent_buckets [RECENT_DEPTH];

  overflow_bucket_marker uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_bucket        (in_bucket),
    .in_fill_count    (in_fill_count),
    .in_fence_value   (in_fence_value),
    .in_available     (in_available),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_bucket_id    (out_bucket_id),
    .out_marked_total (out_marked_total)
  );

  obm_checker checker_inst (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_bucket        (in_bucket),
    .in_fill_count    (in_fill_count),
    .in_fence_value   (in_fence_value),
    .in_available     (in_available),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_bucket_id    (out_bucket_id),
    .out_marked_total (out_marked_total),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap before a request or a result; calm stretches run with no idling at all.
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Present one request at the falling edge and hold it until it is taken.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [BUCKET_W-1:0] bucket,
                              logic [COUNT_WIDTH-1:0] fill, logic [COUNT_WIDTH-1:0] fence,
                              logic [31:0] avail);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_bucket      <= bucket;
    in_fill_count  <= fill;
    in_fence_value <= fence;
    in_available   <= avail;
    do @(posedge clk); while (in_stall);
    sent_count++;
    @(negedge clk);
  endtask

  // Listing requests carry random payload so that unused fields toggle too.
  task automatic send_listing(logic [CMD_W-1:0] cmd);
    send_request(cmd, BUCKET_W'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Mark a bucket from a random source: anywhere, the two focus stripes, or a recent bucket.
  task automatic random_mark();
    logic [BUCKET_W-1:0]    bucket;
    logic [COUNT_WIDTH-1:0] fill;
    logic [COUNT_WIDTH-1:0] fence;
    case ($urandom_range(0, 2))
      0: bucket = BUCKET_W'($urandom);
      1: bucket = BUCKET_W'((($urandom_range(0, 1) == 1) ? focus_a : focus_b)
                            + STRIPES * $urandom_range(0, NUM_BUCKETS / STRIPES - 1));
      default: bucket = recent_buckets[$urandom_range(0, RECENT_DEPTH - 1)];
    endcase
    recent_buckets[$urandom_range(0, RECENT_DEPTH - 1)] = bucket;
    fill = $urandom;
    // Half the fences sit just inside or just past the fill count.
    if ($urandom_range(0, 1) == 1)
      fence = $urandom;
    else
      fence = fill + COUNT_WIDTH'($signed($urandom_range(0, 8)) - 4);
    if ($urandom_range(0, 1) == 1)
      send_request(CMD_MARK_FENCE, bucket, fill, fence, $urandom);
    else
      send_request(CMD_MARK_AVAIL, bucket, fill, fence, $urandom);
  endtask

  // Result side: stall for a drawn number of cycles, then take one result.
  initial begin : result_side
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("overflow_bucket_marker regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_marks;
    int n_next;
    int pick;
    in_valid       = 1'b0;
    in_cmd         = CMD_CLEAR;
    in_bucket      = '0;
    in_fill_count  = '0;
    in_fence_value = '0;
    in_available   = '0;
    out_stall      = 1'b0;
    calm           = 1'b0;
    sent_count     = 0;
    focus_a        = 0;
    focus_b        = STRIPES - 1;
    foreach (recent_buckets[i]) recent_buckets[i] = BUCKET_W'(i * 17);
    rst_n          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: next right after reset acts as a start on an empty store.
    send_request(CMD_NEXT, '0, '0, '0, '0);
    // Fence extremes: fill one past a zero fence, widest and exact sign boundary, equal.
    send_request(CMD_MARK_FENCE, 10'd0, 32'd1, 32'd0, '0);
    send_request(CMD_MARK_FENCE, 10'd1023, 32'd0, 32'hFFFF_FFFF, '0);
    send_request(CMD_MARK_FENCE, 10'd16, 32'h8000_0000, 32'd0, '0);
    send_request(CMD_MARK_FENCE, 10'd32, 32'd0, 32'd0, '0);
    // Available extremes: most negative, most positive, minus one, and re-marking to clear.
    send_request(CMD_MARK_AVAIL, 10'd15, '0, '0, 32'h8000_0000);
    send_request(CMD_MARK_AVAIL, 10'd1008, '0, '0, 32'h7FFF_FFFF);
    send_request(CMD_MARK_AVAIL, 10'd1008, '0, '0, 32'hFFFF_FFFF);
    send_request(CMD_MARK_AVAIL, 10'd16, '0, '0, 32'd0);
    send_request(CMD_NEXT + 3'd1, 10'd555, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    send_listing(CMD_START);
    // Marking during a listing: one bucket ahead of the cursor, one behind it.
    send_request(CMD_MARK_AVAIL, 10'd48, '0, '0, 32'hFFFF_FFFF);
    send_request(CMD_MARK_FENCE, 10'd0, 32'd5, 32'd4, '0);
    send_listing(CMD_NEXT);
    send_request(CMD_NEXT + 3'd2, '1, '1, '1, '1);
    send_request(CMD_NEXT + 3'd3, '0, '0, '0, '0);
    repeat (5) send_listing(CMD_NEXT);
    // Clear with every payload bit high, then next on the emptied store.
    send_request(CMD_CLEAR, '1, '1, '1, '1);
    send_listing(CMD_NEXT);
    send_request(CMD_MARK_FENCE, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFE, '0);
    send_listing(CMD_START);

    // Random part: rounds of marks followed by a listing with marks and noise mixed in.
    while (sent_count < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      focus_a = $urandom_range(0, STRIPES - 1);
      focus_b = $urandom_range(0, STRIPES - 1);
      if ($urandom_range(0, 3) == 0) send_listing(CMD_CLEAR);
      n_marks = $urandom_range(2, 24);
      repeat (n_marks) random_mark();
      if ($urandom_range(0, 5) != 0) send_listing(CMD_START);
      n_next = $urandom_range(1, n_marks + 3);
      repeat (n_next) begin
        pick = $urandom_range(0, 19);
        if (pick < 3)
          random_mark();
        else if (pick == 3)
          send_listing(CMD_NEXT + 3'($urandom_range(1, 3)));
        else
          send_listing(CMD_NEXT);
      end
    end
    in_valid <= 1'b0;

    // Drain every outstanding result, then give the block a few quiet cycles.
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("overflow_bucket_marker regression: pass");
    else
      $display("overflow_bucket_marker regression: fail");
    $finish;
  end

endmodule
